>>> src/error_check_code_generator_defines.svh
// Assertion macros for the error check code generator.
// Included by the top level; no other dependencies.
`ifndef ERROR_CHECK_CODE_GENERATOR_DEFINES_SVH
`define ERROR_CHECK_CODE_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define ECCG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define ECCG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/eccg_pkg.sv
// Package for the error check code generator: mode codes, result type,
// constants and the per-byte check functions. No dependencies.
package eccg_pkg;

  typedef enum logic [2:0] {
    MODE_PARITY   = 3'd0,
    MODE_PARITY2D = 3'd1,
    MODE_CRC32    = 3'd2,
    MODE_HAMMING  = 3'd3,
    MODE_CHECKSUM = 3'd4
  } code_mode_t;

  localparam logic [2:0]  ModeReset = 3'(MODE_CRC32);
  localparam logic [31:0] CrcInit   = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly   = 32'hEDB8_8320;
  localparam logic [15:0] SumMask   = 16'hFFFF;
  localparam int          FifoDepth = 4;

  localparam logic [5:0] Bits1  = 6'd1;
  localparam logic [5:0] Bits4  = 6'd4;
  localparam logic [5:0] Bits8  = 6'd8;
  localparam logic [5:0] Bits16 = 6'd16;
  localparam logic [5:0] Bits32 = 6'd32;

  typedef struct packed {
    logic [31:0] value;
    logic [5:0]  bits;
    logic        fin;
  } result_t;

  // Reflected CRC-32, one byte, unrolled over its eight bits
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

  // 16-bit ones' complement add with end-around carry
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] w);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, w};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // p1 p2 p4 p8, data bit 7 is d0
  function automatic logic [3:0] hamming_bits(input logic [7:0] b);
    return {b[7] ^ b[6] ^ b[4] ^ b[3] ^ b[1],
            b[7] ^ b[5] ^ b[4] ^ b[2] ^ b[1],
            b[6] ^ b[5] ^ b[4] ^ b[0],
            b[3] ^ b[2] ^ b[1] ^ b[0]};
  endfunction

endpackage

>>> src/error_check_code_generator.sv
// Error check code generator: parity, 2D parity, CRC-32, Hamming, checksum.
// Depends on eccg_pkg and error_check_code_generator_defines.svh.
// Each result is registered into the result queue when its byte is accepted.
// Throughput: one byte per cycle while in_ready is high; all accumulators update in the accept cycle.
// A four-entry result queue takes the second result of a 2D parity message
// end; in_ready drops only while the queue holds three or more results.
// Reset: synchronous; mode returns to CRC-32, accumulators and queue clear.
`include "error_check_code_generator_defines.svh"

module error_check_code_generator
  import eccg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  code_mode,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] code_value,
  output logic [5:0]  code_bits,
  output logic        final_result
);

  localparam int PtrW = $clog2(FifoDepth);
  localparam int CntW = $clog2(FifoDepth + 1);

  logic [2:0]  active_mode;
  logic [31:0] crc_register;
  logic        running_parity;
  logic [7:0]  column_parity;
  logic [15:0] ones_complement_sum;
  logic [7:0]  held_high_byte;
  logic        odd_byte_pending;

  result_t          queue [FifoDepth];
  logic [PtrW-1:0]  wr_ptr, rd_ptr;
  logic [CntW-1:0]  count;

  logic        in_fire, out_fire;
  logic        row;
  logic        parity_next;
  logic [7:0]  column_next;
  logic [31:0] crc_next;
  logic [15:0] word, sum_next, final_sum;
  logic        res0_valid, res1_valid;
  result_t     res0, res1;
  logic [1:0]  push_n;

  assign cfg_ready = 1'b1;
  assign in_ready  = (count < CntW'(FifoDepth - 1));
  assign out_valid = (count != '0);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  assign code_value   = queue[rd_ptr].value;
  assign code_bits    = queue[rd_ptr].bits;
  assign final_result = queue[rd_ptr].fin;

  always_comb begin
    row         = ^data_byte;
    parity_next = running_parity ^ row;
    column_next = column_parity ^ data_byte;
    crc_next    = crc32_byte(crc_register, data_byte);
    // a pending high byte pairs with this one; otherwise this byte is high, low is zero
    word        = odd_byte_pending ? {held_high_byte, data_byte} : {data_byte, 8'h00};
    sum_next    = ones_add(ones_complement_sum, word);
    final_sum   = ~sum_next & SumMask;

    res0_valid = 1'b0;
    res1_valid = 1'b0;
    res0       = '0;
    res1       = '{value: {24'h0, column_next}, bits: Bits8, fin: 1'b1};
    unique case (active_mode)
      MODE_PARITY: begin
        res0_valid = end_of_message;
        res0       = '{value: {31'h0, parity_next}, bits: Bits1, fin: 1'b1};
      end
      MODE_PARITY2D: begin
        res0_valid = 1'b1;
        res1_valid = end_of_message;
        res0       = '{value: {31'h0, row}, bits: Bits1, fin: 1'b0};
      end
      MODE_CRC32: begin
        res0_valid = end_of_message;
        res0       = '{value: ~crc_next, bits: Bits32, fin: 1'b1};
      end
      MODE_HAMMING: begin
        res0_valid = 1'b1;
        res0       = '{value: {28'h0, hamming_bits(data_byte)}, bits: Bits4,
                       fin: end_of_message};
      end
      MODE_CHECKSUM: begin
        res0_valid = end_of_message;
        res0       = '{value: {16'h0, final_sum}, bits: Bits16, fin: 1'b1};
      end
      default: begin
        res0_valid = 1'b0;
      end
    endcase
    push_n = in_fire ? ({1'b0, res0_valid} + {1'b0, res1_valid}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_mode         <= ModeReset;
      crc_register        <= CrcInit;
      running_parity      <= 1'b0;
      column_parity       <= '0;
      ones_complement_sum <= '0;
      held_high_byte      <= '0;
      odd_byte_pending    <= 1'b0;
      wr_ptr              <= '0;
      rd_ptr              <= '0;
      count               <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        active_mode <= code_mode;
      end
      if (in_fire) begin
        if (end_of_message) begin
          crc_register        <= CrcInit;
          running_parity      <= 1'b0;
          column_parity       <= '0;
          ones_complement_sum <= '0;
          held_high_byte      <= '0;
          odd_byte_pending    <= 1'b0;
        end else begin
          crc_register   <= crc_next;
          running_parity <= parity_next;
          column_parity  <= column_next;
          if (odd_byte_pending) begin
            ones_complement_sum <= sum_next;
            held_high_byte      <= '0;
            odd_byte_pending    <= 1'b0;
          end else begin
            held_high_byte   <= data_byte;
            odd_byte_pending <= 1'b1;
          end
        end
      end
      wr_ptr <= wr_ptr + PtrW'(push_n);
      rd_ptr <= rd_ptr + PtrW'(out_fire);
      count  <= count + CntW'(push_n) - CntW'(out_fire);
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire && res0_valid) begin
      queue[wr_ptr] <= res0;
    end
    if (in_fire && res1_valid) begin
      queue[wr_ptr + PtrW'(1)] <= res1;
    end
  end

  `ECCG_ASSERT_NEXT(a_count_tracks, clk, rst, 1'b1,
    count == $past(count) + CntW'($past(push_n)) - CntW'($past(out_fire)),
    "result queue count out of step with pushes and pops")
  `ECCG_ASSERT_NOW(a_no_overflow, clk, rst, 1'b1,
    count <= CntW'(FifoDepth), "result queue overflow")
  `ECCG_ASSERT_NEXT(a_clear_on_end, clk, rst, in_fire && end_of_message,
    crc_register == CrcInit && ones_complement_sum == '0 && !odd_byte_pending
    && column_parity == '0 && !running_parity,
    "accumulators not cleared after final byte")

endmodule

>>> sim/tb_top.sv
// Testbench for error_check_code_generator: directed and random byte messages
// in every code mode, checked against an in-bench code predictor.
// Depends on eccg_pkg and the RTL under src.
module tb_top
  import eccg_pkg::*;
();

  localparam int unsigned CycleLimit   = 400000;
  localparam int          HoldCycles   = 300;
  localparam int          SettleCycles = 3;
  localparam int          PhaseItems   = 150;
  localparam int          RandomPhases = 12;
  localparam logic [31:0] CrcSeed      = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcTaps      = 32'hEDB8_8320;
  localparam logic [2:0]  ModeSpare5   = 3'd5;
  localparam logic [2:0]  ModeSpare7   = 3'd7;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} rx_style_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  code_mode = 3'(MODE_CRC32);
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] code_value;
  logic [5:0]  code_bits;
  logic        final_result;

  error_check_code_generator i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .code_mode      (code_mode),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .code_value     (code_value),
    .code_bits      (code_bits),
    .final_result   (final_result)
  );

  initial forever #2 clk = ~clk;

  // Code predictor state, mirrors the block's accumulators
  logic [2:0]  mode_q      = 3'(MODE_CRC32);
  logic [31:0] crc_acc     = CrcSeed;
  logic        parity_acc  = 1'b0;
  logic [7:0]  column_acc  = 8'h00;
  logic [15:0] sum_acc     = 16'h0000;
  logic [7:0]  high_byte   = 8'h00;
  logic        byte_odd    = 1'b0;
  result_t     expected_codes[$];
  result_t     head_code;
  int          fail_count  = 0;
  int          burst_left  = 0;
  int          msg_left    = 0;

  // Receiver: switches among random stall styles, long hold on request
  rx_style_t   rx_style     = RX_OPEN;
  int unsigned rx_tick      = 0;
  int          hold_left    = 0;
  bit          hold_request = 1'b0;

  function automatic logic [31:0] crc_after_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CrcTaps) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [15:0] ones_sum16(input logic [15:0] a, input logic [15:0] w);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, w};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  // p1 p2 p4 p8; masks pick the data bits each check bit covers
  function automatic logic [3:0] hamming_nibble(input logic [7:0] b);
    return {^(b & 8'hDA), ^(b & 8'hB6), ^(b & 8'h71), ^(b & 8'h0F)};
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic predict_codes(input logic [7:0] b, input logic eom);
    logic        row;
    logic [15:0] folded;
    row        = ^b;
    parity_acc = parity_acc ^ row;
    column_acc = column_acc ^ b;
    crc_acc    = crc_after_byte(crc_acc, b);
    if (byte_odd) begin
      sum_acc   = ones_sum16(sum_acc, {high_byte, b});
      byte_odd  = 1'b0;
      high_byte = 8'h00;
    end else begin
      high_byte = b;
      byte_odd  = 1'b1;
    end
    // odd trailing byte is padded with a zero low byte
    folded = byte_odd ? ones_sum16(sum_acc, {high_byte, 8'h00}) : sum_acc;
    case (mode_q)
      MODE_PARITY: begin
        if (eom) expected_codes.push_back('{value: 32'(parity_acc), bits: Bits1, fin: 1'b1});
      end
      MODE_PARITY2D: begin
        expected_codes.push_back('{value: 32'(row), bits: Bits1, fin: 1'b0});
        if (eom) expected_codes.push_back('{value: 32'(column_acc), bits: Bits8, fin: 1'b1});
      end
      MODE_CRC32: begin
        if (eom) expected_codes.push_back('{value: ~crc_acc, bits: Bits32, fin: 1'b1});
      end
      MODE_HAMMING: begin
        expected_codes.push_back('{value: 32'(hamming_nibble(b)), bits: Bits4, fin: eom});
      end
      MODE_CHECKSUM: begin
        if (eom) expected_codes.push_back('{value: {16'd0, ~folded}, bits: Bits16, fin: 1'b1});
      end
      default: ;
    endcase
    if (eom) begin
      crc_acc    = CrcSeed;
      parity_acc = 1'b0;
      column_acc = 8'h00;
      sum_acc    = 16'h0000;
      high_byte  = 8'h00;
      byte_odd   = 1'b0;
    end
  endtask

  // Offer one byte request and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic eom);
    in_valid       <= 1'b1;
    data_byte      <= b;
    end_of_message <= eom;
    do @(posedge clk); while (!in_ready);
    predict_codes(b, eom);
  endtask

  task automatic send_paced(input logic [7:0] b, input logic eom);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    send_byte(b, eom);
    burst_left--;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_codes.size() != 0) @(posedge clk);
    // no-result bytes may still be in flight
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_mode(input logic [2:0] m);
    wait_idle();
    cfg_valid <= 1'b1;
    code_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode_q = m;
  endtask

  task automatic test_reset_mode();
    send_byte(8'h31, 1'b0);
    send_byte(8'h32, 1'b0);
    send_byte(8'h33, 1'b1);
  endtask

  task automatic test_each_mode();
    code_mode_t modes[5] = '{MODE_PARITY, MODE_PARITY2D, MODE_CRC32, MODE_HAMMING,
                             MODE_CHECKSUM};
    foreach (modes[i]) begin
      write_mode(3'(modes[i]));
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hA5, 1'b1);
    end
    // an all-ones checksum word, then a one-byte message
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_unused_modes();
    write_mode(ModeSpare5);
    send_byte(8'h80, 1'b1);
    write_mode(ModeSpare7);
    send_byte(8'h7F, 1'b1);
  endtask

  task automatic test_mode_switch();
    write_mode(3'(MODE_HAMMING));
    send_byte(8'h12, 1'b0);
    write_mode(3'(MODE_CRC32));
    send_byte(8'h34, 1'b1);
  endtask

  task automatic test_random_traffic();
    logic [2:0] fixed_modes[4] = '{3'(MODE_PARITY), 3'(MODE_CHECKSUM), ModeSpare7,
                                   3'(MODE_PARITY2D)};
    logic [2:0] m;
    for (int p = 0; p < RandomPhases; p++) begin
      if (p < 4) m = fixed_modes[p];
      else if ($urandom_range(0, 6) == 0) m = 3'($urandom_range(5, 7));
      else m = 3'($urandom_range(0, 4));
      write_mode(m);
      // a message left open here continues under the next mode
      for (int n = 0; n < PhaseItems; n++) begin
        if (msg_left == 0)
          msg_left = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 80)
                                                 : $urandom_range(1, 12);
        send_paced(pick_byte(), msg_left == 1);
        msg_left--;
      end
    end
  endtask

  task automatic test_backpressure();
    write_mode(3'(MODE_HAMMING));
    hold_request = 1'b1;
    repeat (60) send_byte(pick_byte(), $urandom_range(0, 7) == 0);
    write_mode(3'(MODE_PARITY2D));
    hold_request = 1'b1;
    repeat (60) send_byte(pick_byte(), $urandom_range(0, 2) == 0);
    send_byte(pick_byte(), 1'b1);
    wait_idle();
    msg_left = 0;
  endtask

  always @(posedge clk) begin
    rx_tick++;
    if (rx_tick % 64 == 0) rx_style = rx_style_t'($urandom_range(0, 3));
    if (hold_request) begin
      hold_left    = HoldCycles;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_style)
        RX_OPEN:    out_ready <= 1'b1;
        RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE:  out_ready <= ($urandom_range(0, 3) == 0);
        default:    out_ready <= ((rx_tick % 8) < 5);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_codes.size() == 0) begin
        $error("result with none expected: code_value %h code_bits %0d final_result %b",
               code_value, code_bits, final_result);
        fail_count++;
      end else begin
        head_code = expected_codes.pop_front();
        if (code_value !== head_code.value) begin
          $error("code_value: expected %h, got %h", head_code.value, code_value);
          fail_count++;
        end
        if (code_bits !== head_code.bits) begin
          $error("code_bits: expected %0d, got %0d", head_code.bits, code_bits);
          fail_count++;
        end
        if (final_result !== head_code.fin) begin
          $error("final_result: expected %b, got %b", head_code.fin, final_result);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_mode();
    test_each_mode();
    test_unused_modes();
    test_mode_switch();
    test_random_traffic();
    test_backpressure();
    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_codes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
